/* hw/rtl/sbr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbr_pkg: shared types and constants for the subpartition balancer router
// Child and subpartition counts are powers of two, set by their index widths.
// ----------------------------------------------------------------------------
package sbr_pkg;

    localparam int CHILD_W     = 2;
    localparam int CHILD_COUNT = 1 << CHILD_W;
    localparam int SUB_W       = 5;
    localparam int SUB_COUNT   = 1 << SUB_W;
    localparam int NEXT_W      = $clog2(SUB_COUNT + 1);
    localparam int IDX_W       = 3;
    localparam int SIZE_W      = 32;
    localparam int CFG_IDX_W   = 1;

    typedef enum logic [1:0] {
        OP_STAT  = 2'd0,
        OP_ROUTE = 2'd1,
        OP_CLEAR = 2'd2
    } t_opcode;

    localparam logic [CFG_IDX_W-1:0] CFG_USE_MAP    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TWO_INPUTS = CFG_IDX_W'(1);

    // command from the control stage to the packer
    typedef struct packed {
        logic               stat;
        logic               clear;
        logic               two_inputs;
        logic [SIZE_W-1:0]  build_count;
        logic [SIZE_W-1:0]  probe_count;
        logic [SUB_W-1:0]   route_sub;
    } t_pack_cmd;

    // packer view back to the control stage
    typedef struct packed {
        logic [CHILD_W-1:0] child;
        logic [SIZE_W-1:0]  build_size;
        logic [SIZE_W-1:0]  probe_size;
        logic               overflow;
        logic               map_ready_next;
        logic               map_complete;
        logic [CHILD_W-1:0] map_entry;
    } t_pack_res;

endpackage

/* hw/rtl/sbr_packer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbr_packer: greedy child packing state and subpartition map
// Holds saturating child sizes, current child, fill count and the map.
// ----------------------------------------------------------------------------
module sbr_packer
    import sbr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_pack_cmd i_cmd,
    output t_pack_res o_res
);

    logic [SIZE_W-1:0]  r_bsz [CHILD_COUNT];
    logic [SIZE_W-1:0]  r_psz [CHILD_COUNT];
    logic [CHILD_W-1:0] r_cur;
    logic [NEXT_W-1:0]  r_next;
    logic               r_complete;
    logic [CHILD_W-1:0] r_map [SUB_COUNT];

    logic [SIZE_W-1:0]  n_bsz;
    logic [SIZE_W-1:0]  n_psz;
    logic               biggest;
    logic               stat_ok;
    logic               last_sub;

    function automatic logic [SIZE_W-1:0] sat_add(input logic [SIZE_W-1:0] a,
                                                  input logic [SIZE_W-1:0] b);
        logic [SIZE_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SIZE_W] ? '1 : s[SIZE_W-1:0];
    endfunction

    always_comb begin
        n_bsz   = sat_add(r_bsz[r_cur], i_cmd.build_count);
        n_psz   = sat_add(r_psz[r_cur], i_cmd.probe_count);
        biggest = 1'b1;
        // strictly larger than every other child
        for (int k = 0; k < CHILD_COUNT; k++) begin
            if (CHILD_W'(k) != r_cur && !(n_bsz > r_bsz[k])) begin
                biggest = 1'b0;
            end
        end
    end

    assign stat_ok  = i_cmd.stat && !r_complete;
    assign last_sub = (r_next == NEXT_W'(SUB_COUNT - 1));

    always_comb begin
        o_res.child          = r_complete ? '0 : r_cur;
        o_res.build_size     = r_complete ? '0 : n_bsz;
        o_res.probe_size     = (r_complete || !i_cmd.two_inputs) ? '0 : n_psz;
        o_res.overflow       = r_complete;
        o_res.map_complete   = r_complete;
        o_res.map_entry      = r_map[i_cmd.route_sub];
        if (i_cmd.clear) begin
            o_res.map_ready_next = 1'b0;
        end else if (stat_ok && last_sub) begin
            o_res.map_ready_next = 1'b1;
        end else begin
            o_res.map_ready_next = r_complete;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int k = 0; k < CHILD_COUNT; k++) begin
                r_bsz[k] <= '0;
                r_psz[k] <= '0;
            end
            r_cur      <= '0;
            r_next     <= '0;
            r_complete <= 1'b0;
        end else if (stat_ok) begin
            r_bsz[r_cur] <= n_bsz;
            if (i_cmd.two_inputs) begin
                r_psz[r_cur] <= n_psz;
            end
            if (biggest) begin
                r_cur <= r_cur + CHILD_W'(1);
            end
            r_next <= r_next + NEXT_W'(1);
            if (last_sub) begin
                r_complete <= 1'b1;
            end
        end
    end

    // map entries: no reset, only read once every entry is rewritten
    always_ff @(posedge i_clk) begin
        if (stat_ok) begin
            r_map[r_next[SUB_W-1:0]] <= r_cur;
        end
    end

    a_complete_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_complete |-> r_next == NEXT_W'(SUB_COUNT))
        else $error("map complete with fill count short");

    a_stat_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.stat && !r_complete && !i_cmd.clear) |=> r_next == $past(r_next) + NEXT_W'(1))
        else $error("stat did not advance fill count");

    a_clear_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |=> (r_next == '0 && !r_complete && r_cur == '0))
        else $error("clear left packing state");

endmodule

/* hw/rtl/subpartition_balancer_router.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subpartition_balancer_router: greedy hash-join subpartition balancer
//
// Channels: input transactions (i_in_valid / o_in_ready) carry an opcode and
// its operands: stat (build and probe counts of the next subpartition), route
// (hash key and input side) or clear (restart packing). Every input
// transaction yields exactly one output transaction (o_out_valid /
// i_out_ready). Configuration writes use i_cfg_valid / o_cfg_ready with a
// register index (0 use_map, 1 two_inputs) and are always accepted; write
// them only while the block is idle.
// Path: the accepting edge loads the input register; once the result register
// is free it is loaded from the input register through the packing/route
// logic, and o_out_valid rises with it.
// Throughput: one transaction per cycle while i_out_ready is high; the packer's
// saturating add and the compare against the other child sizes are combinational.
// Reset: synchronous, active low. Child sizes, current child, fill count and
// map-complete clear; use_map and two_inputs set to 1. Map entries are not
// reset; they are read only after the whole map is written again.
// Stall: when the receiver holds i_out_ready low, the result register holds
// and one more transaction waits in the input register; o_in_ready then drops.
// ----------------------------------------------------------------------------
module subpartition_balancer_router
    import sbr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input transactions
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_opcode,
    input  logic [SIZE_W-1:0]    i_build_count,
    input  logic [SIZE_W-1:0]    i_probe_count,
    input  logic [SIZE_W-1:0]    i_hash_key,
    input  logic                 i_input_side,
    // output transactions
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [IDX_W-1:0]     o_child_index,
    output logic [SIZE_W-1:0]    o_child_build_size,
    output logic [SIZE_W-1:0]    o_child_probe_size,
    output logic                 o_map_ready,
    output logic                 o_overflow_error,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic                 i_cfg_data
);

    // config registers
    logic r_use_map;
    logic r_two_inputs;

    // input register
    logic              r_in_valid;
    logic [1:0]        r_op;
    logic [SIZE_W-1:0] r_bc;
    logic [SIZE_W-1:0] r_pc;
    logic [SIZE_W-1:0] r_hk;
    logic              r_side;

    // result register
    logic              r_out_valid;
    logic [IDX_W-1:0]  r_idx;
    logic [SIZE_W-1:0] r_bsz;
    logic [SIZE_W-1:0] r_psz;
    logic              r_ready;
    logic              r_ovf;

    logic              advance;
    logic              fire;
    t_pack_cmd         pack_cmd;
    t_pack_res         pack_res;

    logic [IDX_W-1:0]  n_idx;
    logic [SIZE_W-1:0] n_bsz;
    logic [SIZE_W-1:0] n_psz;
    logic              n_ovf;
    logic [CHILD_W-1:0] route_base;

    // result register frees when empty or being taken this cycle
    assign advance     = !r_out_valid || i_out_ready;
    assign o_in_ready  = !r_in_valid || advance;
    assign fire        = r_in_valid && advance;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_map    <= 1'b1;
            r_two_inputs <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_USE_MAP:    r_use_map    <= i_cfg_data;
                CFG_TWO_INPUTS: r_two_inputs <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_op   <= i_opcode;
            r_bc   <= i_build_count;
            r_pc   <= i_probe_count;
            r_hk   <= i_hash_key;
            r_side <= i_input_side;
        end
    end

    always_comb begin
        pack_cmd.stat        = fire && (r_op == OP_STAT);
        pack_cmd.clear       = fire && (r_op == OP_CLEAR);
        pack_cmd.two_inputs  = r_two_inputs;
        pack_cmd.build_count = r_bc;
        pack_cmd.probe_count = r_pc;
        pack_cmd.route_sub   = r_hk[SUB_W-1:0];
    end

    sbr_packer u_packer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (pack_cmd),
        .o_res   (pack_res)
    );

    // map path only when use_map is set and the map is complete; else hash mod child count
    assign route_base = (r_use_map && pack_res.map_complete) ? pack_res.map_entry
                                                             : r_hk[CHILD_W-1:0];

    always_comb begin
        n_idx = '0;
        n_bsz = '0;
        n_psz = '0;
        n_ovf = 1'b0;
        unique case (r_op)
            OP_STAT: begin
                n_idx = IDX_W'(pack_res.child);
                n_bsz = pack_res.build_size;
                n_psz = pack_res.probe_size;
                n_ovf = pack_res.overflow;
            end
            OP_ROUTE: begin
                // side term added even for a single input
                n_idx = IDX_W'(route_base) + (r_side ? IDX_W'(CHILD_COUNT) : IDX_W'(0));
            end
            default: ;  // clear and unused code: all-zero payload
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_idx   <= n_idx;
            r_bsz   <= n_bsz;
            r_psz   <= n_psz;
            r_ready <= pack_res.map_ready_next;
            r_ovf   <= n_ovf;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_child_index      = r_idx;
    assign o_child_build_size = r_bsz;
    assign o_child_probe_size = r_psz;
    assign o_map_ready        = r_ready;
    assign o_overflow_error   = r_ovf;

    a_ovf_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_overflow_error) |-> o_map_ready)
        else $error("overflow reported before map complete");

    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_overflow_error)
            |-> (o_child_index == '0 && o_child_build_size == '0 && o_child_probe_size == '0))
        else $error("late stat carried nonzero payload");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

endmodule
